// ===== design/m3inv_pkg.sv =====
// ----------------------------------------------------------------------------
// m3inv_pkg
// Shared types and constants for the 3x3 adjugate matrix inverse pipeline.
// ----------------------------------------------------------------------------
package m3inv_pkg;

    // full-width determinant: |det| < 2^96, kept signed with margin
    localparam int DET_W  = 98;
    // determinant magnitude, unsigned
    localparam int DMAG_W = 97;
    // divider remainder: holds twice a value below the magnitude
    localparam int REM_W  = DMAG_W + 1;
    // cofactor: difference of two 64-bit products
    localparam int COF_W  = 65;
    // cofactor magnitude, |c| <= 2^63
    localparam int CMAG_W = 64;
    // quotient bits kept below the overflow flag
    localparam int QUO_W  = 32;
    localparam int N_COF  = 9;

    // cofactor k = m[p0]*m[p1] - m[p2]*m[p3], row-major entry indexes
    localparam logic [3:0] COF_IDX [N_COF][4] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd7, 4'd2, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd4, 4'd2},
        '{4'd6, 4'd5, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd3, 4'd2, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
    };

    typedef struct packed {
        logic signed [31:0] a00;
        logic signed [31:0] a01;
        logic signed [31:0] a02;
        logic signed [31:0] a10;
        logic signed [31:0] a11;
        logic signed [31:0] a12;
        logic signed [31:0] a20;
        logic signed [31:0] a21;
        logic signed [31:0] a22;
    } matrix_t;

    typedef struct packed {
        logic signed [31:0] inv00;
        logic signed [31:0] inv01;
        logic signed [31:0] inv02;
        logic signed [31:0] inv10;
        logic signed [31:0] inv11;
        logic signed [31:0] inv12;
        logic signed [31:0] inv20;
        logic signed [31:0] inv21;
        logic signed [31:0] inv22;
        logic signed [31:0] det_value;
        logic               singular;
    } result_t;

    // one divider stage worth of state for all nine lanes
    typedef struct packed {
        logic [N_COF-1:0][REM_W-1:0] rem;
        logic [N_COF-1:0][QUO_W-1:0] quo;
        logic [N_COF-1:0]            ovf;
        logic [N_COF-1:0]            neg;
        logic [DMAG_W-1:0]           dmag;
        logic                        singular;
        logic [31:0]                 det_value;
    } div_t;

endpackage

// ===== design/m3inv_div_step.sv =====
// ----------------------------------------------------------------------------
// m3inv_div_step
// One restoring-division step for the nine cofactor lanes, registered.
// ----------------------------------------------------------------------------
module m3inv_div_step (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              valid,
    input  m3inv_pkg::div_t   data,
    output logic              out_valid,
    output m3inv_pkg::div_t   out_data
);

    logic            valid_reg;
    m3inv_pkg::div_t data_reg;
    m3inv_pkg::div_t data_next;

    always_comb
    begin
        logic [m3inv_pkg::REM_W-1:0] r2;
        logic [m3inv_pkg::REM_W-1:0] d;
        logic                        ge;
        data_next = data;
        d = {1'b0, data.dmag};
        for (int k = 0; k < m3inv_pkg::N_COF; k++)
        begin
            r2 = {data.rem[k][m3inv_pkg::REM_W-2:0], 1'b0};
            ge = (r2 >= d);
            data_next.rem[k] = ge ? (r2 - d) : r2;
            data_next.quo[k] = {data.quo[k][m3inv_pkg::QUO_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== design/matrix3_inverse_adjugate.sv =====
// ----------------------------------------------------------------------------
// matrix3_inverse_adjugate
// Pipelined 3x3 inverse of a signed Q16.16 matrix by adjugate over determinant.
// ----------------------------------------------------------------------------
// Usage:
//   Present a request on matrix with matrix_valid high; it is taken at a
//   rising edge where matrix_stall is low. One result per request leaves on
//   result, qualified by result_valid and held while result_stall is high.
//   It has seven arithmetic stages (products, cofactors, split determinant
//   products, terms, sum, magnitudes, overflow test), 32 restoring-division
//   stages, one per quotient bit, and an output stage. Throughput is one
//   matrix per cycle unless stalled; every stage holds its own valid bit.
//   The whole pipeline advances together: a stalled receiver with a full
//   output register freezes all stages, and matrix_stall goes high in that
//   same cycle, so nothing is dropped or repeated. Bubbles flow through.
//   Reset clears all valid bits; the data registers need no reset.
//   A zero determinant gives singular = 1 with zero inverse and det_value.
// ----------------------------------------------------------------------------
module matrix3_inverse_adjugate (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                matrix_valid,
    output logic                matrix_stall,
    input  m3inv_pkg::matrix_t  matrix,
    output logic                result_valid,
    input  logic                result_stall,
    output m3inv_pkg::result_t  result
);

    localparam int NDIV = m3inv_pkg::QUO_W;

    // advance everything unless the output holds a result the receiver refuses
    logic en;
    assign en = !result_valid || !result_stall;
    assign matrix_stall = !en;

    logic [7:1] v_reg;

    // ---------------- stage 1: pair products ----------------
    logic signed [31:0] m [9];
    always_comb
    begin
        m[0] = matrix.a00; m[1] = matrix.a01; m[2] = matrix.a02;
        m[3] = matrix.a10; m[4] = matrix.a11; m[5] = matrix.a12;
        m[6] = matrix.a20; m[7] = matrix.a21; m[8] = matrix.a22;
    end

    logic signed [63:0] prod_reg [2*m3inv_pkg::N_COF];
    logic signed [31:0] a0_reg1 [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < m3inv_pkg::N_COF; k++)
            begin
                prod_reg[2*k]   <= 64'(m[m3inv_pkg::COF_IDX[k][0]])
                                 * 64'(m[m3inv_pkg::COF_IDX[k][1]]);
                prod_reg[2*k+1] <= 64'(m[m3inv_pkg::COF_IDX[k][2]])
                                 * 64'(m[m3inv_pkg::COF_IDX[k][3]]);
            end
            a0_reg1[0] <= matrix.a00;
            a0_reg1[1] <= matrix.a01;
            a0_reg1[2] <= matrix.a02;
        end
    end

    // ---------------- stage 2: cofactors ----------------
    logic signed [m3inv_pkg::COF_W-1:0] cof_reg2 [m3inv_pkg::N_COF];
    logic signed [31:0]                 a0_reg2 [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < m3inv_pkg::N_COF; k++)
                cof_reg2[k] <= m3inv_pkg::COF_W'(prod_reg[2*k])
                             - m3inv_pkg::COF_W'(prod_reg[2*k+1]);
            a0_reg2 <= a0_reg1;
        end
    end

    // ---------------- stage 3: split products a0j * cofactor ----------------
    // det = a00*cof0 + a01*cof3 + a02*cof6; cut each 32x65 product in two
    logic signed [64:0] plo_reg [3];
    logic signed [64:0] phi_reg [3];
    logic signed [m3inv_pkg::COF_W-1:0] cof_reg3 [m3inv_pkg::N_COF];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                plo_reg[j] <= 65'(a0_reg2[j]) * $signed({33'd0, cof_reg2[3*j][31:0]});
                phi_reg[j] <= 65'(a0_reg2[j])
                            * 65'($signed(cof_reg2[3*j][m3inv_pkg::COF_W-1:32]));
            end
            cof_reg3 <= cof_reg2;
        end
    end

    // ---------------- stage 4: recombine terms ----------------
    logic signed [m3inv_pkg::DET_W-1:0] term_reg [3];
    logic signed [m3inv_pkg::COF_W-1:0] cof_reg4 [m3inv_pkg::N_COF];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
                term_reg[j] <= (m3inv_pkg::DET_W'(phi_reg[j]) <<< 32)
                             + m3inv_pkg::DET_W'(plo_reg[j]);
            cof_reg4 <= cof_reg3;
        end
    end

    // ---------------- stage 5: determinant ----------------
    logic signed [m3inv_pkg::DET_W-1:0] det_reg;
    logic signed [m3inv_pkg::COF_W-1:0] cof_reg5 [m3inv_pkg::N_COF];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det_reg  <= term_reg[0] + term_reg[1] + term_reg[2];
            cof_reg5 <= cof_reg4;
        end
    end

    // ---------------- stage 6: magnitudes, signs, det_value ----------------
    logic signed [m3inv_pkg::DET_W-1:0] det_abs;
    logic signed [65:0]                 det_shift;
    logic [31:0]                        det_sat;

    always_comb
    begin
        det_abs   = det_reg[m3inv_pkg::DET_W-1] ? -det_reg : det_reg;
        // floor(det / 2^32)
        det_shift = $signed(det_reg[m3inv_pkg::DET_W-1:32]);
        if (det_shift > 66'sd2147483647)
            det_sat = 32'h7FFF_FFFF;
        else if (det_shift < -66'sd2147483648)
            det_sat = 32'h8000_0000;
        else
            det_sat = det_shift[31:0];
    end

    logic [m3inv_pkg::DMAG_W-1:0] dmag_reg6;
    logic                         sing_reg6;
    logic [31:0]                  detv_reg6;
    logic [m3inv_pkg::CMAG_W-1:0] cmag_reg6 [m3inv_pkg::N_COF];
    logic [m3inv_pkg::N_COF-1:0]  neg_reg6;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dmag_reg6 <= det_abs[m3inv_pkg::DMAG_W-1:0];
            sing_reg6 <= (det_reg == '0);
            detv_reg6 <= det_sat;
            for (int k = 0; k < m3inv_pkg::N_COF; k++)
            begin
                cmag_reg6[k] <= cof_reg5[k][m3inv_pkg::COF_W-1]
                              ? m3inv_pkg::CMAG_W'(-cof_reg5[k])
                              : m3inv_pkg::CMAG_W'(cof_reg5[k]);
                neg_reg6[k]  <= cof_reg5[k][m3inv_pkg::COF_W-1]
                              ^ det_reg[m3inv_pkg::DET_W-1];
            end
        end
    end

    // ---------------- stage 7: overflow test, divider setup ----------------
    // a quotient of 2^32 or more shows as |c| >= |det|; zero the remainder then
    m3inv_pkg::div_t div_next;
    m3inv_pkg::div_t div_reg;

    always_comb
    begin
        logic [m3inv_pkg::DMAG_W-1:0] cm;
        div_next           = '0;
        div_next.dmag      = dmag_reg6;
        div_next.singular  = sing_reg6;
        div_next.det_value = detv_reg6;
        div_next.neg       = neg_reg6;
        for (int k = 0; k < m3inv_pkg::N_COF; k++)
        begin
            cm = m3inv_pkg::DMAG_W'(cmag_reg6[k]);
            div_next.ovf[k] = (cm >= dmag_reg6);
            div_next.rem[k] = (cm >= dmag_reg6) ? '0 : m3inv_pkg::REM_W'(cmag_reg6[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            div_reg <= div_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[6:1], matrix_valid};
    end

    // ---------------- divider chain: one quotient bit per stage ----------------
    logic            dv [NDIV+1];
    m3inv_pkg::div_t dd [NDIV+1];

    assign dv[0] = v_reg[7];
    assign dd[0] = div_reg;

    for (genvar i = 0; i < NDIV; i++)
    begin : g_div
        m3inv_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid     (dv[i]),
            .data      (dd[i]),
            .out_valid (dv[i+1]),
            .out_data  (dd[i+1])
        );
    end

    // ---------------- output stage: sign, saturation, singular ----------------
    logic [31:0] inv [m3inv_pkg::N_COF];

    always_comb
    begin
        logic [m3inv_pkg::QUO_W-1:0] q;
        logic                        big;
        for (int k = 0; k < m3inv_pkg::N_COF; k++)
        begin
            q   = dd[NDIV].quo[k];
            big = dd[NDIV].ovf[k] || q[m3inv_pkg::QUO_W-1];
            if (dd[NDIV].singular)
                inv[k] = '0;
            else if (dd[NDIV].neg[k])
                inv[k] = big ? 32'h8000_0000 : -q;
            else
                inv[k] = big ? 32'h7FFF_FFFF : q;
        end
    end

    logic                 out_valid_reg;
    m3inv_pkg::result_t   result_reg;
    m3inv_pkg::result_t   result_next;

    always_comb
    begin
        result_next.inv00     = inv[0];
        result_next.inv01     = inv[1];
        result_next.inv02     = inv[2];
        result_next.inv10     = inv[3];
        result_next.inv11     = inv[4];
        result_next.inv12     = inv[5];
        result_next.inv20     = inv[6];
        result_next.inv21     = inv[7];
        result_next.inv22     = inv[8];
        result_next.det_value = dd[NDIV].singular ? '0 : dd[NDIV].det_value;
        result_next.singular  = dd[NDIV].singular;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dv[NDIV];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            result_reg <= result_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = result_reg;

endmodule

// ===== bench/tb_matrix3_inverse_adjugate.sv =====
// ----------------------------------------------------------------------------
// tb_matrix3_inverse_adjugate
// Self-checking bench for the pipelined 3x3 adjugate inverse. A local model
// computes the exact determinant and quotients at full width; each result is
// compared field by field with the oldest predicted one, under random idling
// on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_matrix3_inverse_adjugate;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 60;

    logic               clk;
    logic               rst_n;
    logic               matrix_valid;
    logic               matrix_stall;
    m3inv_pkg::matrix_t matrix;
    logic               result_valid;
    logic               result_stall;
    m3inv_pkg::result_t result;

    // idle rates in percent, changed per phase
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    // cycles of forced receiver hold-off still to run
    int unsigned hold_cycles;

    m3inv_pkg::result_t inverse_queue[$];
    int      error_count;
    int      request_count;
    int      result_count;
    int      singular_count;
    int      idle_cycles;

    matrix3_inverse_adjugate u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .matrix_valid (matrix_valid),
        .matrix_stall (matrix_stall),
        .matrix       (matrix),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // saturate a signed 160-bit value to Q16.16
    function automatic logic signed [31:0] clamp_q16(logic signed [159:0] v);
        if (v > 160'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -160'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // exact inverse: determinant by Sarrus, cofactor * 2^32 / det truncated
    function automatic m3inv_pkg::result_t predict_inverse(m3inv_pkg::matrix_t mx);
        logic signed [159:0] e [9];
        logic signed [159:0] det;
        logic signed [159:0] cof;
        logic signed [159:0] quo;
        logic signed [31:0]  inv [9];
        m3inv_pkg::result_t r;
        int p [9][4];
        p = '{'{4,8,5,7}, '{7,2,1,8}, '{1,5,4,2}, '{6,5,3,8}, '{0,8,2,6},
              '{3,2,0,5}, '{3,7,4,6}, '{1,6,0,7}, '{0,4,1,3}};
        e[0] = mx.a00; e[1] = mx.a01; e[2] = mx.a02;
        e[3] = mx.a10; e[4] = mx.a11; e[5] = mx.a12;
        e[6] = mx.a20; e[7] = mx.a21; e[8] = mx.a22;
        det = e[0]*e[4]*e[8] + e[1]*e[5]*e[6] + e[2]*e[7]*e[3]
            - e[2]*e[4]*e[6] - e[0]*e[5]*e[7] - e[3]*e[1]*e[8];
        r = '0;
        if (det == 0)
        begin
            r.singular = 1'b1;
            return r;
        end
        // arithmetic shift floors toward minus infinity
        r.det_value = clamp_q16(det >>> 32);
        for (int k = 0; k < 9; k++)
        begin
            cof = e[p[k][0]] * e[p[k][1]] - e[p[k][2]] * e[p[k][3]];
            // signed division truncates toward zero
            quo = (cof <<< 32) / det;
            inv[k] = clamp_q16(quo);
        end
        {r.inv00, r.inv01, r.inv02, r.inv10, r.inv11, r.inv12,
         r.inv20, r.inv21, r.inv22} = {inv[0], inv[1], inv[2], inv[3], inv[4],
                                       inv[5], inv[6], inv[7], inv[8]};
        return r;
    endfunction

    task automatic check_field(string name, logic signed [31:0] exp_v,
                               logic signed [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected %0d actual %0d", name, exp_v, act_v);
            error_count++;
        end
    endtask

    // drive the receiver stall: random idling plus the hold-off window
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else if (hold_cycles != 0)
        begin
            result_stall <= 1'b1;
            hold_cycles  <= hold_cycles - 1;
        end
        else
            result_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // compare each accepted result against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            m3inv_pkg::result_t want;
            result_count++;
            if (inverse_queue.size() == 0)
            begin
                $error("result with no request outstanding");
                error_count++;
            end
            else
            begin
                want = inverse_queue.pop_front();
                check_field("inv00", want.inv00, result.inv00);
                check_field("inv01", want.inv01, result.inv01);
                check_field("inv02", want.inv02, result.inv02);
                check_field("inv10", want.inv10, result.inv10);
                check_field("inv11", want.inv11, result.inv11);
                check_field("inv12", want.inv12, result.inv12);
                check_field("inv20", want.inv20, result.inv20);
                check_field("inv21", want.inv21, result.inv21);
                check_field("inv22", want.inv22, result.inv22);
                check_field("det_value", want.det_value, result.det_value);
                check_field("singular", want.singular, result.singular);
            end
        end
    end

    // watchdog: count cycles where neither channel moves
    always @(posedge clk)
    begin
        if ((matrix_valid && !matrix_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // offer one request, idle first at the sender rate, hold until taken;
    // valid stays high afterwards so the next request can follow at once
    task automatic send_matrix(m3inv_pkg::matrix_t mx);
        while ($urandom_range(99) < send_idle_pct)
        begin
            matrix_valid <= 1'b0;
            @(posedge clk);
        end
        matrix_valid <= 1'b1;
        matrix       <= mx;
        @(posedge clk);
        while (matrix_stall)
            @(posedge clk);
        inverse_queue.push_back(predict_inverse(mx));
        request_count++;
        if (predict_inverse(mx).singular)
            singular_count++;
    endtask

    function automatic logic [31:0] rand_entry();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
            2: return $signed($urandom_range(8)) - 4 <<< 16;
            3: return $signed($urandom_range(511)) - 256;
            default: return $signed($urandom_range(32'h3FFFF)) - 32'h1FFFF;
        endcase
    endfunction

    function automatic m3inv_pkg::matrix_t rand_matrix();
        m3inv_pkg::matrix_t mx;
        mx = {rand_entry(), rand_entry(), rand_entry(), rand_entry(),
              rand_entry(), rand_entry(), rand_entry(), rand_entry(), rand_entry()};
        // now and then copy row 0 to row 2, zero row 1 or copy column 0 to column 1
        case ($urandom_range(7))
            0: {mx.a20, mx.a21, mx.a22} = {mx.a00, mx.a01, mx.a02};
            1: {mx.a10, mx.a11, mx.a12} = 96'd0;
            2: {mx.a01, mx.a11, mx.a21} = {mx.a00, mx.a10, mx.a20};
            default: ;
        endcase
        return mx;
    endfunction

    // drop valid, then wait for every outstanding result
    task automatic wait_drained();
        matrix_valid <= 1'b0;
        while (inverse_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic test_directed();
        localparam logic [31:0] ONE = 32'h00010000;
        logic [31:0] mx_v, mn_v;
        mx_v = 32'h7FFFFFFF;
        mn_v = 32'h80000000;
        // identity, zero (singular), diagonal scaling
        send_matrix({ONE, 32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0, ONE});
        send_matrix('0);
        send_matrix({32'h00020000, 32'd0, 32'd0, 32'd0, 32'h00040000, 32'd0,
                     32'd0, 32'd0, 32'hFFFF8000});
        // all extremes, singular: two of rank one, one with a repeated row
        send_matrix({9{mx_v}});
        send_matrix({9{mn_v}});
        send_matrix({mx_v, mn_v, mx_v, mn_v, mx_v, mn_v, mx_v, mn_v, mx_v});
        // diagonal extremes: determinant overflows det_value
        send_matrix({mx_v, 32'd0, 32'd0, 32'd0, mx_v, 32'd0, 32'd0, 32'd0, mx_v});
        send_matrix({mn_v, 32'd0, 32'd0, 32'd0, mn_v, 32'd0, 32'd0, 32'd0, mn_v});
        send_matrix({mn_v, 32'd1, 32'd0, 32'd0, mx_v, 32'd0, 32'd0, 32'd0, mn_v});
        // tiny determinant: nonzero but floors to zero or -1, inverse saturates
        send_matrix({32'd1, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd1});
        send_matrix({32'hFFFFFFFF, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0,
                     32'd0, 32'd0, 32'd1});
        // permutation with negative determinant
        send_matrix({32'd0, ONE, 32'd0, ONE, 32'd0, 32'd0, 32'd0, 32'd0, ONE});
        // duplicate rows, singular
        send_matrix({ONE, 32'h00020000, 32'h00030000, ONE, 32'h00020000,
                     32'h00030000, 32'h00050000, 32'd7, 32'd9});
        // general full-range pattern
        send_matrix({32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 32'hF0F0F0F0,
                     32'h55555555, 32'hAAAAAAAA, 32'h00000001, 32'hFFFFFFFE, mx_v});
        wait_drained();
    endtask

    task automatic test_random(int unsigned n, int unsigned s_pct, int unsigned r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (n) send_matrix(rand_matrix());
        wait_drained();
    endtask

    // hold the receiver off long enough that the pipeline fills and stalls input
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles   = 200;
        repeat (80) send_matrix(rand_matrix());
        wait_drained();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        matrix_valid   = 1'b0;
        matrix         = '0;
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        hold_cycles    = 0;
        error_count    = 0;
        request_count  = 0;
        result_count   = 0;
        singular_count = 0;
        idle_cycles    = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(330, 17, 56);
        test_random(330, 56, 17);
        test_random(330, 0, 0);
        test_backpressure();

        $display("covered %0d matrices, %0d results, %0d singular, with idling and hold-off",
                 request_count, result_count, singular_count);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
